/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/vtc_pkg.sv */
// ---------------------------------------------------------------------------
// vtc_pkg
// types and constants shared by the version tag compare block
// ---------------------------------------------------------------------------
package vtc_pkg;

    localparam int NUMBER_WIDTH = 24;
    localparam int VALUE_W      = 24;
    localparam int CH_W         = 8;
    localparam int FIELD_LIMIT  = 999999;

    localparam int OUT_USED_W   = 3 * VALUE_W + 3;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // m_tdata bit positions
    localparam int OK_POS    = 0;
    localparam int MAJOR_LSB = 1;
    localparam int MINOR_LSB = MAJOR_LSB + VALUE_W;
    localparam int PATCH_LSB = MINOR_LSB + VALUE_W;
    localparam int RC_POS    = PATCH_LSB + VALUE_W;
    localparam int NEWER_POS = RC_POS + 1;

    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;
    localparam logic [CH_W-1:0] CH_DOT  = 8'h2e;
    localparam logic [CH_W-1:0] CH_DASH = 8'h2d;
    localparam logic [CH_W-1:0] CH_R    = 8'h72;
    localparam logic [CH_W-1:0] CH_C    = 8'h63;

    typedef enum logic [2:0] {
        PH_SKIP        = 3'd0,
        PH_MAJOR       = 3'd1,
        PH_MINOR_START = 3'd2,
        PH_MINOR       = 3'd3,
        PH_PATCH_START = 3'd4,
        PH_PATCH       = 3'd5,
        PH_DONE        = 3'd6,
        PH_FAIL        = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        RC_IDLE = 2'd0,
        RC_DASH = 2'd1,
        RC_R    = 2'd2
    } rc_prog_t;

    typedef struct packed {
        logic step;
        logic clear;
    } vtc_ctrl_t;

    typedef struct packed {
        logic                    ok;
        logic [NUMBER_WIDTH-1:0] major;
        logic [NUMBER_WIDTH-1:0] minor;
        logic [NUMBER_WIDTH-1:0] patch;
        logic                    rc_found;
    } vtc_status_t;

endpackage

/* rtl/vtc_parser.sv */
// ---------------------------------------------------------------------------
// vtc_parser
// per-character tag parser with digit accumulation and -rc search
// ---------------------------------------------------------------------------
module vtc_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  vtc_pkg::vtc_ctrl_t        ctrl,
    input  logic [vtc_pkg::CH_W-1:0]  ch,
    output vtc_pkg::vtc_status_t      status
);
    import vtc_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [NUMBER_WIDTH-1:0] accum_reg, accum_next;
    logic [NUMBER_WIDTH-1:0] major_reg, major_next;
    logic [NUMBER_WIDTH-1:0] minor_reg, minor_next;
    rc_prog_t                rc_prog_reg, rc_prog_next;
    logic                    rc_found_reg, rc_found_next;

    logic                    is_digit;
    logic                    is_dot;
    logic                    over;
    logic [NUMBER_WIDTH-1:0] digit_val;
    logic [NUMBER_WIDTH-1:0] mul_add;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_dot    = (ch == CH_DOT);
    assign over      = (accum_reg > NUMBER_WIDTH'(FIELD_LIMIT));
    assign digit_val = NUMBER_WIDTH'(ch[3:0]);
    assign mul_add   = (accum_reg << 3) + (accum_reg << 1) + digit_val;

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.clear)
        begin
            phase_next = PH_SKIP;
        end
        else if (ctrl.step)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (is_digit)
                        phase_next = PH_MAJOR;
                end
                PH_MAJOR, PH_MINOR:
                begin
                    if (is_digit)
                        phase_next = over ? PH_FAIL : phase_reg;
                    else if (is_dot)
                        phase_next = (phase_reg == PH_MAJOR) ? PH_MINOR_START
                                                             : PH_PATCH_START;
                    else
                        phase_next = PH_FAIL;
                end
                PH_MINOR_START, PH_PATCH_START:
                begin
                    if (is_digit)
                        phase_next = (phase_reg == PH_MINOR_START) ? PH_MINOR : PH_PATCH;
                    else
                        phase_next = PH_FAIL;
                end
                PH_PATCH:
                begin
                    if (is_digit)
                        phase_next = over ? PH_FAIL : PH_PATCH;
                    else
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // field values
    always_comb
    begin
        accum_next = accum_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        if (ctrl.clear)
        begin
            accum_next = '0;
            major_next = '0;
            minor_next = '0;
        end
        else if (ctrl.step)
        begin
            unique case (phase_reg)
                PH_SKIP, PH_MINOR_START, PH_PATCH_START:
                begin
                    if (is_digit)
                        accum_next = digit_val;
                end
                PH_MAJOR, PH_MINOR:
                begin
                    if (is_digit && !over)
                    begin
                        accum_next = mul_add;
                    end
                    else if (is_dot)
                    begin
                        accum_next = '0;
                        if (phase_reg == PH_MAJOR)
                            major_next = accum_reg;
                        else
                            minor_next = accum_reg;
                    end
                end
                PH_PATCH:
                begin
                    if (is_digit && !over)
                        accum_next = mul_add;
                end
                default:
                begin
                    accum_next = accum_reg;
                end
            endcase
        end
    end

    // -rc search
    always_comb
    begin
        rc_prog_next  = rc_prog_reg;
        rc_found_next = rc_found_reg;
        if (ctrl.clear)
        begin
            rc_prog_next  = RC_IDLE;
            rc_found_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (ch == CH_DASH)
                rc_prog_next = RC_DASH;
            else if (rc_prog_reg == RC_DASH && ch == CH_R)
                rc_prog_next = RC_R;
            else if (rc_prog_reg == RC_R && ch == CH_C)
            begin
                rc_prog_next  = RC_IDLE;
                rc_found_next = 1'b1;
            end
            else
                rc_prog_next = RC_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            accum_reg    <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            rc_prog_reg  <= RC_IDLE;
            rc_found_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            rc_prog_reg  <= rc_prog_next;
            rc_found_reg <= rc_found_next;
        end
    end

    // outputs
    always_comb
    begin
        status.ok       = (phase_reg == PH_PATCH) || (phase_reg == PH_DONE);
        status.major    = major_reg;
        status.minor    = minor_reg;
        status.patch    = accum_reg;
        status.rc_found = rc_found_reg;
    end

endmodule

/* rtl/vtc_result.sv */
// ---------------------------------------------------------------------------
// vtc_result
// latest tag store, triple comparison and result register
// ---------------------------------------------------------------------------
module vtc_result
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            is_current,
    input  vtc_pkg::vtc_status_t            status,
    output logic                            slot_free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vtc_pkg::OUT_DATA_W-1:0]  m_tdata,   // tag_ok, major_value, minor_value,
                                                       // patch_value, rc_mark, newer, zero pad
    output logic                            m_tuser    // from_current
);
    import vtc_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    logic                    cur_reg;
    logic                    ok_reg;
    logic [VALUE_W-1:0]      major_reg, minor_reg, patch_reg;
    logic                    rc_reg;
    logic                    newer_reg;

    logic                    latest_valid_reg;
    logic [NUMBER_WIDTH-1:0] lat_major_reg, lat_minor_reg, lat_patch_reg;

    logic [NUMBER_WIDTH-1:0] v_major, v_minor, v_patch;
    logic                    newer_calc;

    assign v_major = status.ok ? status.major : '0;
    assign v_minor = status.ok ? status.minor : '0;
    assign v_patch = status.ok ? status.patch : '0;

    always_comb
    begin
        newer_calc = 1'b0;
        if (is_current && status.ok && latest_valid_reg)
        begin
            if (lat_major_reg != v_major)
                newer_calc = (lat_major_reg > v_major);
            else if (lat_minor_reg != v_minor)
                newer_calc = (lat_minor_reg > v_minor);
            else if (lat_patch_reg != v_patch)
                newer_calc = (lat_patch_reg > v_patch);
            else
                newer_calc = status.rc_found;
        end
    end

    assign slot_free      = !out_valid_reg || m_tready;
    assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            latest_valid_reg <= 1'b0;
            lat_major_reg    <= '0;
            lat_minor_reg    <= '0;
            lat_patch_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load && !is_current)
            begin
                latest_valid_reg <= status.ok;
                lat_major_reg    <= v_major;
                lat_minor_reg    <= v_minor;
                lat_patch_reg    <= v_patch;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg   <= is_current;
            ok_reg    <= status.ok;
            major_reg <= v_major[VALUE_W-1:0];
            minor_reg <= v_minor[VALUE_W-1:0];
            patch_reg <= v_patch[VALUE_W-1:0];
            rc_reg    <= status.rc_found;
            newer_reg <= newer_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = cur_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), newer_reg, rc_reg,
                       patch_reg, minor_reg, major_reg, ok_reg};

endmodule

/* rtl/version_tag_compare.sv */
// the result register loads as the terminator advances out of the input register
// throughput: one character per cycle, held back only while a finished result is stalled
// and the next character in the input register is a terminator
// the parser state updates once per character on the input register's advance
// reset: rst_n clears the parser, the stored latest tag and all valid flags at once
// ---------------------------------------------------------------------------
// version_tag_compare
// streaming version tag parser and latest/current comparator
// ---------------------------------------------------------------------------
module version_tag_compare
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vtc_pkg::CH_W-1:0]        s_tdata,   // ch
    input  logic                            s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vtc_pkg::OUT_DATA_W-1:0]  m_tdata,   // tag_ok, major_value, minor_value,
                                                       // patch_value, rc_mark, newer, zero pad
    output logic                            m_tuser    // from_current
);
    import vtc_pkg::*;

    logic            in_valid_reg;
    logic            in_type_reg;
    logic [CH_W-1:0] in_ch_reg;

    logic            is_term;
    logic            advance;
    logic            slot_free;
    vtc_ctrl_t       ctrl;
    vtc_status_t     status;

    assign is_term    = (in_ch_reg == CH_NUL);
    assign advance    = in_valid_reg && (!is_term || slot_free);
    assign s_tready   = !in_valid_reg || advance;
    // step in the upper bit, clear in the lower
    assign ctrl       = {advance && !is_term, advance && is_term};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg <= s_tuser;
            in_ch_reg   <= s_tdata;
        end
    end

    vtc_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .ch     (in_ch_reg),
        .status (status)
    );

    vtc_result u_result
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ctrl.clear),
        .is_current (in_type_reg),
        .status     (status),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* rtl/vtc_checker.sv */
// ---------------------------------------------------------------------------
// vtc_checker
// port level checks on the result stream of version_tag_compare
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [vtc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            m_tuser
);
    import vtc_pkg::*;

    // stalled item stays
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // failed parse carries no numbers and never wins
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, m_tvalid && !m_tdata[OK_POS], m_tdata[PATCH_LSB+VALUE_W-1:MAJOR_LSB] == '0 && !m_tdata[NEWER_POS])
    // latest tag results never claim newer
    `ASSERT_IMPLY(a_latest_newer, clk, rst_n, m_tvalid && !m_tuser, !m_tdata[NEWER_POS])

endmodule

bind version_tag_compare vtc_checker u_vtc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_version_tag_compare.sv */
// ---------------------------------------------------------------------------
// tb_version_tag_compare
// self-checking bench for the version tag parser and comparator: a short
// table of hand-written tags, then random tag groups and noise, fed byte
// by byte with random gaps on both sides and one long output stall; each
// result is compared with typed rows or a behavioural parser in the bench
// ---------------------------------------------------------------------------
module tb_version_tag_compare;
    import vtc_pkg::*;

    localparam int RANDOM_CHARS  = 1700;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 60;
    localparam int SETTLE_CYCLES = 10;
    localparam int CALM_FROM     = 700;
    localparam int CALM_TO       = 1100;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic               from_current;
        logic               ok;
        logic [VALUE_W-1:0] major;
        logic [VALUE_W-1:0] minor;
        logic [VALUE_W-1:0] patch;
        logic               rc;
        logic               newer;
    } tag_result_t;

    typedef struct packed {
        logic            req;
        logic [CH_W-1:0] ch;
        logic            has_exp;
        tag_result_t     exp;
    } tag_char_t;

    typedef struct packed {
        logic        req;
        logic        mix;
        logic        has_exp;
        tag_result_t exp;
    } row_info_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [CH_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // parser state of the bench
    phase_t                  phase        = PH_SKIP;
    logic [NUMBER_WIDTH-1:0] accum        = '0;
    logic [NUMBER_WIDTH-1:0] held_major   = '0;
    logic [NUMBER_WIDTH-1:0] held_minor   = '0;
    rc_prog_t                rc_step      = RC_IDLE;
    logic                    rc_seen      = 1'b0;
    logic [NUMBER_WIDTH-1:0] latest_tag[3];
    logic                    latest_ok    = 1'b0;

    tag_char_t   tag_chars[$];
    tag_result_t expected_tags[$];
    string       row_text[$];
    row_info_t   row_info[$];

    bit calm         = 1'b0;
    int n_checked    = 0;
    int n_parsed     = 0;
    int n_newer      = 0;
    int n_rc         = 0;
    int n_mismatch   = 0;
    int quiet_cycles = 0;

    version_tag_compare i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic digit_into_accum(input logic [CH_W-1:0] c);
        if (accum > FIELD_LIMIT)
            phase = PH_FAIL;
        else
            accum = NUMBER_WIDTH'(accum * 10 + (c - CH_ZERO));
    endtask

    // one byte through the parser; a zero byte closes the tag
    task automatic parse_tag_char(input logic req, input logic [CH_W-1:0] c,
                                  output bit emitted, output tag_result_t res);
        logic                    dig;
        logic                    settled;
        logic [NUMBER_WIDTH-1:0] tag_v[3];
        int                      i;
        dig     = (c >= CH_ZERO) && (c <= CH_NINE);
        emitted = 1'b0;
        res     = '0;
        if (c != CH_NUL)
        begin
            if (c == CH_DASH)
                rc_step = RC_DASH;
            else if (rc_step == RC_DASH && c == CH_R)
                rc_step = RC_R;
            else if (rc_step == RC_R && c == CH_C)
            begin
                rc_seen = 1'b1;
                rc_step = RC_IDLE;
            end
            else
                rc_step = RC_IDLE;
            case (phase)
                PH_SKIP:
                    if (dig)
                    begin
                        accum = NUMBER_WIDTH'(c - CH_ZERO);
                        phase = PH_MAJOR;
                    end
                PH_MAJOR, PH_MINOR:
                    if (dig)
                        digit_into_accum(c);
                    else if (c == CH_DOT)
                    begin
                        if (phase == PH_MAJOR)
                        begin
                            held_major = accum;
                            phase      = PH_MINOR_START;
                        end
                        else
                        begin
                            held_minor = accum;
                            phase      = PH_PATCH_START;
                        end
                        accum = '0;
                    end
                    else
                        phase = PH_FAIL;
                PH_MINOR_START, PH_PATCH_START:
                    if (dig)
                    begin
                        accum = NUMBER_WIDTH'(c - CH_ZERO);
                        if (phase == PH_MINOR_START)
                            phase = PH_MINOR;
                        else
                            phase = PH_PATCH;
                    end
                    else
                        phase = PH_FAIL;
                PH_PATCH:
                    if (dig)
                        digit_into_accum(c);
                    else
                        phase = PH_DONE;
                default:
                    ;
            endcase
        end
        else
        begin
            emitted          = 1'b1;
            res.from_current = req;
            res.ok           = (phase == PH_PATCH) || (phase == PH_DONE);
            tag_v[0]         = res.ok ? held_major : '0;
            tag_v[1]         = res.ok ? held_minor : '0;
            tag_v[2]         = res.ok ? accum : '0;
            res.major        = tag_v[0];
            res.minor        = tag_v[1];
            res.patch        = tag_v[2];
            res.rc           = rc_seen;
            if (req)
            begin
                if (res.ok && latest_ok)
                begin
                    res.newer = rc_seen;
                    settled   = 1'b0;
                    for (i = 0; i < 3; i++)
                        if (!settled && latest_tag[i] != tag_v[i])
                        begin
                            res.newer = latest_tag[i] > tag_v[i];
                            settled   = 1'b1;
                        end
                end
            end
            else
            begin
                latest_ok = res.ok;
                for (i = 0; i < 3; i++)
                    latest_tag[i] = tag_v[i];
            end
            phase      = PH_SKIP;
            accum      = '0;
            held_major = '0;
            held_minor = '0;
            rc_step    = RC_IDLE;
            rc_seen    = 1'b0;
        end
    endtask

    task automatic take_char(input tag_char_t item);
        bit          emitted;
        tag_result_t res;
        parse_tag_char(item.req, item.ch, emitted, res);
        if (emitted)
            expected_tags.push_back(item.has_exp ? item.exp : res);
    endtask

    task automatic push_char(input logic req, input logic [CH_W-1:0] c);
        tag_char_t item;
        item     = '0;
        item.req = req;
        item.ch  = c;
        tag_chars.push_back(item);
    endtask

    task automatic add_text(input string s, input logic req, input logic mix);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(mix ? logic'($urandom_range(0, 1)) : req, s[i]);
    endtask

    task automatic end_tag(input logic req, input logic has_exp, input tag_result_t exp);
        tag_char_t item;
        item         = '0;
        item.req     = req;
        item.ch      = CH_NUL;
        item.has_exp = has_exp;
        item.exp     = exp;
        tag_chars.push_back(item);
    endtask

    task automatic add_row(input string text, input logic req, input logic mix,
                           input logic has_exp, input logic ok, input int unsigned maj,
                           input int unsigned min, input int unsigned pat,
                           input logic rc, input logic newer);
        row_info_t info;
        info                  = '0;
        info.req              = req;
        info.mix              = mix;
        info.has_exp          = has_exp;
        info.exp.from_current = req;
        info.exp.ok           = ok;
        info.exp.major        = VALUE_W'(maj);
        info.exp.minor        = VALUE_W'(min);
        info.exp.patch        = VALUE_W'(pat);
        info.exp.rc           = rc;
        info.exp.newer        = newer;
        row_text.push_back(text);
        row_info.push_back(info);
    endtask

    function automatic int unsigned pick_number();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 9999999;
            2:       return $urandom_range(0, 9);
            7, 8:    return $urandom_range(0, 9999999);
            9:       return $urandom_range(10000000, 99999999);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic int unsigned nudge(input int unsigned v);
        if ($urandom_range(0, 1) || v == 0)
            return v + 1;
        return v - 1;
    endfunction

    function automatic string num_text(input int unsigned v);
        if ($urandom_range(0, 7) == 0)
            return {"0", $sformatf("%0d", v)};
        return $sformatf("%0d", v);
    endfunction

    task automatic add_random_tag(input logic req, input int unsigned maj,
                                  input int unsigned min, input int unsigned pat);
        string body;
        logic  mix;
        int    i;
        mix = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 4))
            0:       add_text("v", req, mix);
            1:       add_text("version-", req, mix);
            2:       add_text("rel ", req, mix);
            default: ;
        endcase
        case ($urandom_range(0, 11))
            0:       body = {num_text(maj), ".", num_text(min)};
            1:       body = {num_text(maj), "..", num_text(pat)};
            2:       body = {num_text(maj), ".", num_text(min), "_", num_text(pat)};
            default: body = {num_text(maj), ".", num_text(min), ".", num_text(pat)};
        endcase
        add_text(body, req, mix);
        case ($urandom_range(0, 9))
            0:       add_text("-rc", req, mix);
            1:       add_text("-rc3", req, mix);
            2:       add_text("-beta", req, mix);
            3:       add_text(".4-rc", req, mix);
            4:       add_text("-r-rc", req, mix);
            5:
                for (i = 0; i < $urandom_range(1, 3); i++)
                    push_char(req, CH_W'($urandom_range(1, 255)));
            default: ;
        endcase
        end_tag(req, 1'b0, '0);
    endtask

    // garbage bytes, or broken runs of digits, dots and rc pieces
    task automatic add_noise_tag();
        string pool;
        int    len;
        int    i;
        bit    raw;
        pool = "0123456789..-rc";
        len  = $urandom_range(0, 12);
        raw  = bit'($urandom_range(0, 1));
        for (i = 0; i < len; i++)
            if (raw)
                push_char(logic'($urandom_range(0, 1)), CH_W'($urandom_range(1, 255)));
            else
                push_char(logic'($urandom_range(0, 1)),
                          pool[$urandom_range(0, pool.len() - 1)]);
        end_tag(logic'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic report_mismatch(input string what, input tag_result_t want,
                                   input tag_result_t seen);
        n_mismatch++;
        if (n_mismatch <= REPORT_MAX)
            $display("%s: expected cur=%0d ok=%0d %0d.%0d.%0d rc=%0d newer=%0d, ",
                     what, want.from_current, want.ok, want.major, want.minor, want.patch,
                     want.rc, want.newer,
                     "got cur=%0d ok=%0d %0d.%0d.%0d rc=%0d newer=%0d",
                     seen.from_current, seen.ok, seen.major,
                     seen.minor, seen.patch, seen.rc, seen.newer);
    endtask

    always @(posedge clk)
    begin : check_results
        tag_result_t seen;
        tag_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.from_current = m_tuser;
            seen.ok           = m_tdata[OK_POS];
            seen.major        = m_tdata[MAJOR_LSB +: VALUE_W];
            seen.minor        = m_tdata[MINOR_LSB +: VALUE_W];
            seen.patch        = m_tdata[PATCH_LSB +: VALUE_W];
            seen.rc           = m_tdata[RC_POS];
            seen.newer        = m_tdata[NEWER_POS];
            n_checked++;
            n_parsed += seen.ok;
            n_newer  += seen.newer;
            n_rc     += seen.rc;
            if (expected_tags.size() == 0)
                report_mismatch("result with nothing pending", '0, seen);
            else
            begin
                want = expected_tags.pop_front();
                if (seen !== want)
                    report_mismatch("result mismatch", want, seen);
            end
        end
    end

    initial
    begin : drive_ready
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_once && n_checked >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d results pending",
                         quiet_cycles, expected_tags.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : drive_chars
        int          r;
        int          target;
        int          next_idx;
        int unsigned maj;
        int unsigned min;
        int unsigned pat;
        int unsigned cmaj;
        int unsigned cmin;
        int unsigned cpat;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        latest_tag[0] = '0;
        latest_tag[1] = '0;
        latest_tag[2] = '0;

        //       text                       req   mix   typed ok maj      min      pat      rc newer
        add_row("1.2.3",                    1'b0, 1'b0, 1'b1, 1, 1,       2,       3,       0, 0);
        add_row("v1.2.3",                   1'b1, 1'b0, 1'b1, 1, 1,       2,       3,       0, 0);
        add_row("9999999.9999999.9999999",  1'b0, 1'b0, 1'b1, 1, 9999999, 9999999, 9999999, 0, 0);
        add_row("0.0.0-rc",                 1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("10000000.0.0",             1'b1, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("",                         1'b0, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("1.2.3",                    1'b1, 1'b0, 1'b1, 1, 1,       2,       3,       0, 0);
        add_row("2.0.0-rc1",                1'b0, 1'b0, 1'b1, 1, 2,       0,       0,       1, 0);
        add_row("release 1.9.9",            1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("2.0.0-rc",                 1'b1, 1'b0, 1'b1, 1, 2,       0,       0,       1, 1);
        add_row("2.0.0",                    1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("2.0.1",                    1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("1..2",                     1'b1, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("1.2x3",                    1'b1, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("abc-r-c",                  1'b1, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("12.",                      1'b1, 1'b0, 1'b1, 0, 0,       0,       0,       0, 0);
        add_row("-rc 3.4.5.6 beta",         1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("\3771.2.3\200",            1'b0, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("4.5.6",                    1'b0, 1'b1, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("4.5.7",                    1'b1, 1'b1, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("7.8.9-r",                  1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);
        add_row("1.2.3--rc",                1'b1, 1'b0, 1'b0, 0, 0,       0,       0,       0, 0);

        for (r = 0; r < row_text.size(); r++)
        begin
            add_text(row_text[r], row_info[r].req, row_info[r].mix);
            end_tag(row_info[r].req, row_info[r].has_exp, row_info[r].exp);
        end

        // a latest tag followed by current tags mostly close to it, with some noise between
        target = tag_chars.size() + RANDOM_CHARS;
        while (tag_chars.size() < target)
        begin
            if ($urandom_range(0, 99) < 15)
                add_noise_tag();
            else
            begin
                maj = pick_number();
                min = pick_number();
                pat = pick_number();
                add_random_tag(1'b0, maj, min, pat);
                repeat ($urandom_range(1, 3))
                begin
                    cmaj = maj;
                    cmin = min;
                    cpat = pat;
                    case ($urandom_range(0, 5))
                        2: cmaj = nudge(maj);
                        3: cmin = nudge(min);
                        4: cpat = nudge(pat);
                        5:
                        begin
                            cmaj = pick_number();
                            cmin = pick_number();
                            cpat = pick_number();
                        end
                        default: ;
                    endcase
                    add_random_tag(1'b1, cmaj, cmin, cpat);
                end
            end
        end

        while (rst_n !== 1'b1)
            @(posedge clk);
        next_idx = 0;
        while (next_idx < tag_chars.size())
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                take_char(tag_chars[next_idx]);
                next_idx++;
            end
            calm = (next_idx >= CALM_FROM) && (next_idx < CALM_TO);
            if (!s_tvalid || s_tready)
            begin
                if (next_idx < tag_chars.size() && (calm || $urandom_range(0, 99) >= 37))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tag_chars[next_idx].ch;
                    s_tuser  <= tag_chars[next_idx].req;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end

        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d table rows plus random tags and noise",
                 tag_chars.size(), row_text.size());
        $display("checked %0d results: %0d parsed, %0d with rc mark, %0d newer",
                 n_checked, n_parsed, n_rc, n_newer);
        if (n_mismatch == 0 && expected_tags.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* version_tag_compare.f */
+incdir+rtl
rtl/vtc_pkg.sv
rtl/vtc_parser.sv
rtl/vtc_result.sv
rtl/version_tag_compare.sv
rtl/vtc_checker.sv
tb/tb_version_tag_compare.sv
